/* hw/rtl/swsq_pkg.sv */
// ----------------------------------------------------------------------------
// swsq_pkg
// Shared types and constants for the stack with scan queries.
// ----------------------------------------------------------------------------
package swsq_pkg;

	localparam int DEPTH   = 8;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int SUM_W   = 35;
	localparam int FIDX_W  = 3;
	localparam int REQ_W   = 3;
	localparam int STAT_W  = 2;
	localparam int TDATA_W = 104;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TOP    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SUM    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_MAXMIN = 3'd4;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UDF = 2'd2;

	// What goes into the output register when a request finishes
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_OVF,
		RES_UDF,
		RES_WORD,
		RES_SCAN
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     push;
		logic     pop;
		logic     rd_top;
		logic     scan_start;
		logic     scan_rd;
		logic     res_load;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/swsq_ctrl.sv */
// ----------------------------------------------------------------------------
// swsq_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module swsq_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [swsq_pkg::REQ_W-1:0] req,
	input  swsq_pkg::dp_stat_t      st,
	output swsq_pkg::dp_cmd_t       cmd
);
	import swsq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_FINISH
	} state_t;

	state_t   state_q;
	res_sel_t res_sel_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.res_sel = res_sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (req)
						REQ_PUSH:   cmd.push = !st.full;
						REQ_POP: begin
							cmd.rd_top = !st.empty;
							cmd.pop    = !st.empty;
						end
						REQ_TOP:    cmd.rd_top = !st.empty;
						REQ_SUM,
						REQ_MAXMIN,
						REQ_SEARCH: cmd.scan_start = !st.empty;
						default:    cmd.load = 1'b1;
					endcase
				end
			end
			S_SCAN:   cmd.scan_rd = 1'b1;
			S_FINISH: cmd.res_load = st.out_free;
			default:  cmd.res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_sel_q <= RES_ZERO;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (req)
							REQ_PUSH: begin
								state_q   <= S_FINISH;
								res_sel_q <= st.full ? RES_OVF : RES_ZERO;
							end
							REQ_POP,
							REQ_TOP: begin
								state_q   <= S_FINISH;
								res_sel_q <= st.empty ? RES_UDF : RES_WORD;
							end
							REQ_SUM,
							REQ_MAXMIN,
							REQ_SEARCH: begin
								res_sel_q <= st.empty ? RES_UDF : RES_SCAN;
								state_q   <= st.empty ? S_FINISH : S_SCAN;
							end
							default: begin
								state_q   <= S_FINISH;
								res_sel_q <= RES_ZERO;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (st.scan_last)
						state_q <= S_SCAN_END;
				end
				// last read word still lands in the accumulators here
				S_SCAN_END: state_q <= S_FINISH;
				S_FINISH: begin
					if (st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/swsq_dp.sv */
// ----------------------------------------------------------------------------
// swsq_dp
// Stack memory, fill count, scan accumulators and the result register.
// ----------------------------------------------------------------------------
module swsq_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  swsq_pkg::dp_cmd_t           cmd,
	output swsq_pkg::dp_stat_t          st,
	input  logic [swsq_pkg::REQ_W-1:0]  req,
	input  logic [swsq_pkg::WORD_W-1:0] value_in,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [swsq_pkg::STAT_W-1:0] status,
	output logic signed [swsq_pkg::WORD_W-1:0] data_out,
	output logic signed [swsq_pkg::WORD_W-1:0] min_out,
	output logic signed [swsq_pkg::SUM_W-1:0]  sum_out,
	output logic                        found,
	output logic [swsq_pkg::FIDX_W-1:0] found_index
);
	import swsq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_m1;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data_q;
	logic              rdv_q;
	logic              first_q;
	logic [REQ_W-1:0]  op_q;
	logic [WORD_W-1:0] val_q;

	logic signed [SUM_W-1:0]  acc_q;
	logic signed [WORD_W-1:0] max_q;
	logic signed [WORD_W-1:0] min_q;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic signed [WORD_W-1:0] rd_s;
	logic                     res_valid_q;

	logic [STAT_W-1:0]        res_status;
	logic signed [WORD_W-1:0] res_data;
	logic signed [WORD_W-1:0] res_min;
	logic signed [SUM_W-1:0]  res_sum;
	logic                     res_found;
	logic [FIDX_W-1:0]        res_fidx;

	assign count_m1 = count_q - CNT_W'(1);
	assign rd_addr  = cmd.rd_top ? count_m1[IDX_W-1:0] : scan_idx_q;
	assign rd_s     = $signed(rd_data_q);

	assign st.empty     = (count_q == '0);
	assign st.full      = (count_q == CNT_W'(DEPTH));
	assign st.scan_last = (CNT_W'(scan_idx_q) == count_m1);
	assign st.out_free  = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.push)
			mem[count_q[IDX_W-1:0]] <= value_in;
		if (cmd.rd_top || cmd.scan_rd)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			scan_idx_q  <= '0;
			rdv_q       <= 1'b0;
			first_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.push)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.pop)
				count_q <= count_m1;
			if (cmd.scan_start)
				scan_idx_q <= '0;
			else if (cmd.scan_rd)
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			rdv_q <= cmd.scan_rd;
			if (cmd.scan_start)
				first_q <= 1'b1;
			else if (rdv_q)
				first_q <= 1'b0;
			if (cmd.res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// scan accumulators, fed one stored word per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req;
			val_q <= value_in;
		end
		if (cmd.scan_rd)
			rd_idx_q <= scan_idx_q;
		if (cmd.scan_start) begin
			acc_q     <= '0;
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
		end else if (rdv_q) begin
			acc_q <= acc_q + SUM_W'(rd_s);
			if (first_q || rd_s > max_q)
				max_q <= rd_s;
			if (first_q || rd_s < min_q)
				min_q <= rd_s;
			if (!hit_q && rd_data_q == val_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_q;
			end
		end
	end

	always_comb begin
		res_status = STAT_OK;
		res_data   = '0;
		res_min    = '0;
		res_sum    = '0;
		res_found  = 1'b0;
		res_fidx   = '0;
		case (cmd.res_sel)
			RES_OVF:  res_status = STAT_OVF;
			RES_UDF:  res_status = STAT_UDF;
			RES_WORD: res_data   = rd_s;
			RES_SCAN: begin
				case (op_q)
					REQ_SUM: res_sum = acc_q;
					REQ_MAXMIN: begin
						res_data = max_q;
						res_min  = min_q;
					end
					REQ_SEARCH: begin
						res_found = hit_q;
						res_fidx  = FIDX_W'(hit_idx_q);
					end
					default: res_status = STAT_OK;
				endcase
			end
			default: res_status = STAT_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status      <= res_status;
			data_out    <= res_data;
			min_out     <= res_min;
			sum_out     <= res_sum;
			found       <= res_found;
			found_index <= res_fidx;
		end
	end

endmodule

/* hw/rtl/stack_with_scan_queries_core.sv */
// ----------------------------------------------------------------------------
// stack_with_scan_queries_core
// Fixed-depth stack of signed words with sum, max/min and search queries.
//
//  channel | dir | tdata                          | tuser
//  s_*     | in  | value_in                       | req_type
//  m_*     | out | data_out, min_out, sum_out,    | status
//          |     | found, found_index             |
//
// Push, pop, top, unused codes and any empty/full case: decode in idle, then
// load the result. Sum, max/min, search: one stored word read per cycle
// through the single memory read port, then the result is loaded.
// Reset empties the stack; memory contents are not cleared.
// A finished result sits in the output register; the next request is taken
// and worked on meanwhile, and waits only to load its own result.
// ----------------------------------------------------------------------------
module stack_with_scan_queries_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [swsq_pkg::TDATA_W-73:0] s_tdata,  // [31:0] value_in
	input  logic [swsq_pkg::REQ_W-1:0]   s_tuser,   // [2:0] req_type
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] data_out, [63:32] min_out, [98:64] sum_out, [99] found,
	// [102:100] found_index, [103] zero
	output logic [swsq_pkg::TDATA_W-1:0] m_tdata,
	output logic [swsq_pkg::STAT_W-1:0]  m_tuser    // [1:0] status
);
	import swsq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	logic signed [WORD_W-1:0] data_out;
	logic signed [WORD_W-1:0] min_out;
	logic signed [SUM_W-1:0]  sum_out;
	logic                     found;
	logic [FIDX_W-1:0]        found_index;

	swsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.req      (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	swsq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.req         (s_tuser),
		.value_in    (s_tdata),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.status      (m_tuser),
		.data_out    (data_out),
		.min_out     (min_out),
		.sum_out     (sum_out),
		.found       (found),
		.found_index (found_index)
	);

	assign m_tdata = {1'b0, found_index, found, sum_out, min_out, data_out};

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> st.out_free)
		else $error("result loaded over a pending transfer");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_PUSH && !st.full) |=> !st.empty)
		else $error("stack empty after a push");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> !st.empty)
		else $error("scan read on empty stack");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_rd || cmd.res_load) |-> !s_tready)
		else $error("request taken while busy");

endmodule
